>>> hdl/vector_display_list_scanner_macros.svh
// Assertion macros shared by the vector display list scanner modules.
`ifndef VECTOR_DISPLAY_LIST_SCANNER_MACROS_SVH
`define VECTOR_DISPLAY_LIST_SCANNER_MACROS_SVH
`ifndef SYNTHESIS
`define VDLS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("vdls assertion failed in %m");
`define VDLS_ASSERT_NEXT(label, clk, rst, cond, nxt) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) \
    else $error("vdls assertion failed in %m");
`else
`define VDLS_ASSERT(label, clk, rst, prop)
`define VDLS_ASSERT_NEXT(label, clk, rst, cond, nxt)
`endif
`endif

>>> hdl/vdls_pkg.sv
// Types and constants of the vector display list scanner.
`timescale 1ns / 1ps
package vdls_pkg;

  localparam int ADDR_W      = 16;
  localparam int COUNT_W     = 13;
  localparam int OFS_W       = 8;
  localparam int WORD_W      = 16;
  localparam int SLOT_W      = 8;
  localparam int SUM_W       = 17;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_PUSH  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_IGNORED = 2'd2;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_PUSH,
    OP_WRITE,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [ADDR_W-1:0]  base;
    logic [COUNT_W-1:0] count;
    logic               count_zero;
    logic [OFS_W-1:0]   x;
    logic [OFS_W-1:0]   y;
    logic [ADDR_W-1:0]  waddr;
    logic [WORD_W-1:0]  wdata;
  } item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  base;
    logic [COUNT_W-1:0] count;
    logic [OFS_W-1:0]   x;
    logic [OFS_W-1:0]   y;
  } desc_t;

endpackage

>>> hdl/vdls_ram.sv
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
module vdls_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/vdls_front.sv
// Front end: input handshake and item classification.
`timescale 1ns / 1ps
module vdls_front #(
  parameter int POINT_DEPTH = 4096,
  localparam int PAW = $clog2(POINT_DEPTH)
) (
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  mode,
  input  logic [PAW-1:0]              point_base,
  input  logic [vdls_pkg::COUNT_W-1:0] point_count,
  input  logic [vdls_pkg::OFS_W-1:0]  x_offset,
  input  logic [vdls_pkg::OFS_W-1:0]  y_offset,
  input  logic [PAW-1:0]              point_address,
  input  logic [vdls_pkg::WORD_W-1:0] point_value,
  input  logic                        q_full,
  output logic                        q_push,
  output vdls_pkg::item_t             q_item
);

  localparam bit POW2 = ((1 << PAW) == POINT_DEPTH);

  logic [PAW:0] waddr_ext;
  logic [PAW:0] waddr_red;

  assign busy   = q_full;
  assign q_push = start && !q_full;

  always_comb begin
    waddr_ext = {1'b0, point_address};
    waddr_red = waddr_ext;
    if (!POW2 && (waddr_ext >= (PAW+1)'(POINT_DEPTH))) begin
      waddr_red = waddr_ext - (PAW+1)'(POINT_DEPTH);
    end

    unique case (mode)
      vdls_pkg::MODE_TICK:  q_item.op = vdls_pkg::OP_TICK;
      vdls_pkg::MODE_PUSH:  q_item.op = vdls_pkg::OP_PUSH;
      vdls_pkg::MODE_WRITE: q_item.op = vdls_pkg::OP_WRITE;
      default:              q_item.op = vdls_pkg::OP_CLEAR;
    endcase
    q_item.base       = vdls_pkg::ADDR_W'(point_base);
    q_item.count      = point_count;
    q_item.count_zero = (point_count == '0);
    q_item.x          = x_offset;
    q_item.y          = y_offset;
    q_item.waddr      = vdls_pkg::ADDR_W'(waddr_red[PAW-1:0]);
    q_item.wdata      = point_value;
  end

endmodule

>>> hdl/vdls_queue.sv
// Two-entry item queue between the front end and the back end.
`timescale 1ns / 1ps
`include "vector_display_list_scanner_macros.svh"
module vdls_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  vdls_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output vdls_pkg::item_t head
);

  localparam int CW = vdls_pkg::QUEUE_AW + 1;

  vdls_pkg::item_t               entries [vdls_pkg::QUEUE_DEPTH];
  logic [vdls_pkg::QUEUE_AW-1:0] wp;
  logic [vdls_pkg::QUEUE_AW-1:0] rp;
  logic [CW-1:0]                 count;

  assign full  = (count == CW'(vdls_pkg::QUEUE_DEPTH));
  assign valid = (count != '0);
  assign head  = entries[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wp] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `VDLS_ASSERT(a_queue_no_overflow, clk, rst, !(push && full))
  `VDLS_ASSERT(a_queue_no_underflow, clk, rst, !(pop && !valid))

endmodule

>>> hdl/vdls_back.sv
// Back end: descriptor list, point memory and round-robin scan sequencer.
`timescale 1ns / 1ps
`include "vector_display_list_scanner_macros.svh"
module vdls_back #(
  parameter int LIST_DEPTH  = 256,
  parameter int POINT_DEPTH = 4096,
  localparam int PAW = $clog2(POINT_DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  vdls_pkg::item_t              q_item,
  output logic                         q_pop,
  output logic                         done,
  output logic                         cursor_valid,
  output logic [vdls_pkg::WORD_W-1:0]  cursor,
  output logic [1:0]                   status,
  output logic [vdls_pkg::SLOT_W-1:0]  slot
);

  localparam int SW    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int LTW   = $clog2(LIST_DEPTH + 1);
  localparam int CW    = SW + 1;
  localparam int SUMW  = vdls_pkg::SUM_W;
  localparam bit POW2  = ((1 << PAW) == POINT_DEPTH);
  localparam int DESCW = $bits(vdls_pkg::desc_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DESC,
    S_ADDR,
    S_PT
  } state_t;

  state_t                        state;
  logic                          second;
  logic [LTW-1:0]                list_top;
  logic [LTW-1:0]                hwm;
  logic [SW-1:0]                 scan_shape;
  logic [vdls_pkg::COUNT_W-1:0]  scan_point;
  logic [SUMW-1:0]               sum;
  logic [vdls_pkg::OFS_W-1:0]    px;
  logic [vdls_pkg::OFS_W-1:0]    py;

  logic                          list_full;
  logic                          push_ok;
  logic                          entry_ok;
  logic [vdls_pkg::COUNT_W-1:0]  cnt;
  logic                          advance;
  logic [CW-1:0]                 shape_inc;
  logic [SW-1:0]                 shape_next;
  logic                          addr_ok;
  logic [15:0]                   top_ext;

  logic                          desc_we;
  vdls_pkg::desc_t               desc_wr;
  logic                          desc_re;
  logic [SW-1:0]                 desc_raddr;
  logic [DESCW-1:0]              desc_raw;
  vdls_pkg::desc_t               desc_rd;
  logic                          pt_we;
  logic                          pt_re;
  logic [vdls_pkg::WORD_W-1:0]   pt_rd;

  assign desc_rd = vdls_pkg::desc_t'(desc_raw);
  assign top_ext = 16'(list_top);

  always_comb begin
    q_pop      = (state == S_IDLE) && q_valid;
    list_full  = (list_top >= LTW'(LIST_DEPTH));
    push_ok    = q_pop && (q_item.op == vdls_pkg::OP_PUSH) && !list_full && !q_item.count_zero;
    entry_ok   = (LTW'(scan_shape) < hwm);
    cnt        = entry_ok ? desc_rd.count : '0;
    advance    = !second && (scan_point >= cnt);
    shape_inc  = CW'(scan_shape) + CW'(1);
    shape_next = (shape_inc >= CW'(list_top)) ? '0 : shape_inc[SW-1:0];
    addr_ok    = POW2 || (sum < SUMW'(POINT_DEPTH));

    desc_we       = push_ok;
    desc_wr.base  = q_item.base;
    desc_wr.count = q_item.count;
    desc_wr.x     = q_item.x;
    desc_wr.y     = q_item.y;

    desc_re    = 1'b0;
    desc_raddr = scan_shape;
    if (q_pop && (q_item.op == vdls_pkg::OP_TICK) && (list_top != '0)) begin
      desc_re = 1'b1;
    end
    if ((state == S_DESC) && advance) begin
      desc_re    = 1'b1;
      desc_raddr = shape_next;
    end

    pt_we = q_pop && (q_item.op == vdls_pkg::OP_WRITE);
    pt_re = (state == S_ADDR) && addr_ok;
  end

  vdls_ram #(
    .WIDTH (DESCW),
    .DEPTH (LIST_DEPTH)
  ) u_desc_ram (
    .clk   (clk),
    .we    (desc_we),
    .waddr (list_top[SW-1:0]),
    .wdata (desc_wr),
    .re    (desc_re),
    .raddr (desc_raddr),
    .rdata (desc_raw)
  );

  vdls_ram #(
    .WIDTH (vdls_pkg::WORD_W),
    .DEPTH (POINT_DEPTH)
  ) u_point_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (q_item.waddr[PAW-1:0]),
    .wdata (q_item.wdata),
    .re    (pt_re),
    .raddr (sum[PAW-1:0]),
    .rdata (pt_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      second     <= 1'b0;
      done       <= 1'b0;
      list_top   <= '0;
      hwm        <= '0;
      scan_shape <= '0;
      scan_point <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cursor_valid <= 1'b0;
            cursor       <= '0;
            status       <= vdls_pkg::STATUS_OK;
            slot         <= '0;
            unique case (q_item.op)
              vdls_pkg::OP_TICK: begin
                if (list_top == '0) begin
                  done <= 1'b1;
                end else begin
                  state  <= S_DESC;
                  second <= 1'b0;
                end
              end
              vdls_pkg::OP_PUSH: begin
                done <= 1'b1;
                if (list_full) begin
                  status <= vdls_pkg::STATUS_FULL;
                end else if (q_item.count_zero) begin
                  status <= vdls_pkg::STATUS_IGNORED;
                end else begin
                  slot     <= top_ext[vdls_pkg::SLOT_W-1:0];
                  list_top <= list_top + 1'b1;
                  if (list_top == hwm) begin
                    hwm <= hwm + 1'b1;
                  end
                end
              end
              vdls_pkg::OP_WRITE: begin
                done <= 1'b1;
              end
              vdls_pkg::OP_CLEAR: begin
                done     <= 1'b1;
                list_top <= '0;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_DESC: begin
          if (advance) begin
            scan_point <= '0;
            scan_shape <= shape_next;
            second     <= 1'b1;
          end else if (cnt == '0) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            sum   <= SUMW'(desc_rd.base[PAW-1:0]) + SUMW'(scan_point);
            px    <= desc_rd.x;
            py    <= desc_rd.y;
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          if (!addr_ok) begin
            sum <= sum - SUMW'(POINT_DEPTH);
          end else begin
            state <= S_PT;
          end
        end
        S_PT: begin
          cursor       <= pt_rd + {8'h00, px} + {py, 8'h00};
          cursor_valid <= 1'b1;
          done         <= 1'b1;
          scan_point   <= scan_point + 1'b1;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `VDLS_ASSERT(a_top_within_hwm, clk, rst, list_top <= hwm)
  `VDLS_ASSERT(a_hwm_bound, clk, rst, hwm <= LTW'(LIST_DEPTH))
  `VDLS_ASSERT_NEXT(a_push_grows_list, clk, rst, push_ok, list_top != '0)

endmodule

>>> hdl/vector_display_list_scanner.sv
// Top level of the vector display list scanner.
// Usage: drive mode and its operand ports with start high; the item is taken
// at a rising edge where start is high and busy is low. busy rises while the
// two-entry item queue is full. Every item yields exactly one result: done is
// high for one cycle with cursor_valid, cursor, status and slot; the receiver
// cannot hold results off. Writes, pushes, clears and ticks on an empty list
// finish from the back end's idle state. A tick that reads a point passes the
// descriptor RAM read and then the dependent point RAM read, with a second
// descriptor read when the scan moves to the next shape; when POINT_DEPTH is
// not a power of two, each extra multiple of the depth in base plus index
// adds a subtraction of the depth before the point read. Items are handled
// one at a time in the back end, which takes the next item from the queue
// only in its idle state. Reset clears the list top, the scan position and the
// descriptor fill mark; point memory holds no defined contents until written.
`timescale 1ns / 1ps
module vector_display_list_scanner #(
  parameter int LIST_DEPTH  = 256,
  parameter int POINT_DEPTH = 4096,
  localparam int PAW = $clog2(POINT_DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    mode,
  input  logic [PAW-1:0]                point_base,
  input  logic [vdls_pkg::COUNT_W-1:0]  point_count,
  input  logic [vdls_pkg::OFS_W-1:0]    x_offset,
  input  logic [vdls_pkg::OFS_W-1:0]    y_offset,
  input  logic [PAW-1:0]                point_address,
  input  logic [vdls_pkg::WORD_W-1:0]   point_value,
  output logic                          done,
  output logic                          cursor_valid,
  output logic [vdls_pkg::WORD_W-1:0]   cursor,
  output logic [1:0]                    status,
  output logic [vdls_pkg::SLOT_W-1:0]   slot
);

  logic            q_full;
  logic            q_push;
  vdls_pkg::item_t q_in;
  logic            q_pop;
  logic            q_valid;
  vdls_pkg::item_t q_head;

  vdls_front #(
    .POINT_DEPTH (POINT_DEPTH)
  ) u_front (
    .start         (start),
    .busy          (busy),
    .mode          (mode),
    .point_base    (point_base),
    .point_count   (point_count),
    .x_offset      (x_offset),
    .y_offset      (y_offset),
    .point_address (point_address),
    .point_value   (point_value),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (q_in)
  );

  vdls_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  vdls_back #(
    .LIST_DEPTH  (LIST_DEPTH),
    .POINT_DEPTH (POINT_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_head),
    .q_pop        (q_pop),
    .done         (done),
    .cursor_valid (cursor_valid),
    .cursor       (cursor),
    .status       (status),
    .slot         (slot)
  );

endmodule

>>> tb/vector_display_list_scanner_tb.sv
// Self-checking testbench for the vector display list scanner: directed and random items.
`timescale 1ns / 1ps
module vector_display_list_scanner_tb;
  import vdls_pkg::*;

  localparam int LIST_N  = 256;
  localparam int POINT_N = 4096;
  localparam int PAW     = $clog2(POINT_N);

  typedef struct packed {
    op_t                op;
    logic [PAW-1:0]     base;
    logic [COUNT_W-1:0] count;
    logic [OFS_W-1:0]   x;
    logic [OFS_W-1:0]   y;
    logic [PAW-1:0]     waddr;
    logic [WORD_W-1:0]  wdata;
  } list_item_t;

  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] cursor;
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
  } beam_result_t;

  class beam_scoreboard;
    logic [PAW-1:0]     shape_base[LIST_N];
    logic [COUNT_W-1:0] shape_count[LIST_N];
    logic [OFS_W-1:0]   shape_x[LIST_N];
    logic [OFS_W-1:0]   shape_y[LIST_N];
    int                 top;
    int                 scan_slot;
    logic [COUNT_W-1:0] scan_idx;
    logic [WORD_W-1:0]  points[POINT_N];
    bit                 point_set[POINT_N];
    beam_result_t       pending[$];
    int                 failures;
    int                 items;
    int                 cursors;
    int                 placed;
    int                 refused;
    int                 empties;
    int                 writes;
    int                 clears;

    function new();
      for (int i = 0; i < LIST_N; i++) begin
        shape_base[i]  = '0;
        shape_count[i] = '0;
        shape_x[i]     = '0;
        shape_y[i]     = '0;
      end
      for (int i = 0; i < POINT_N; i++) begin
        points[i]    = '0;
        point_set[i] = 1'b0;
      end
      top       = 0;
      scan_slot = 0;
      scan_idx  = '0;
      failures  = 0;
      items     = 0;
      cursors   = 0;
      placed    = 0;
      refused   = 0;
      empties   = 0;
      writes    = 0;
      clears    = 0;
    endfunction

    // Slot and index the next tick lands on; returns 1 when it reads a point.
    function bit tick_target(output int s, output logic [COUNT_W-1:0] idx);
      s   = scan_slot % LIST_N;
      idx = scan_idx;
      if (top == 0) return 1'b0;
      if (idx >= shape_count[s]) begin
        idx = '0;
        s   = s + 1;
        if (s >= top) s = 0;
      end
      return shape_count[s] != '0;
    endfunction

    function int point_of(int s, logic [COUNT_W-1:0] idx);
      return (int'(shape_base[s]) + int'(idx)) % POINT_N;
    endfunction

    function void note_item(list_item_t it);
      beam_result_t       exp;
      int                 s;
      int                 addr;
      logic [COUNT_W-1:0] idx;
      exp   = '0;
      items = items + 1;
      case (it.op)
        OP_TICK: begin
          if (tick_target(s, idx)) begin
            addr       = point_of(s, idx);
            exp.valid  = 1'b1;
            exp.cursor = points[addr] + shape_x[s] + {shape_y[s], 8'h00};
            idx        = idx + 1'b1;
            cursors    = cursors + 1;
          end
          scan_slot = s;
          scan_idx  = idx;
        end
        OP_PUSH: begin
          if (top >= LIST_N) begin
            exp.status = STATUS_FULL;
            refused    = refused + 1;
          end else if (it.count == '0) begin
            exp.status = STATUS_IGNORED;
            empties    = empties + 1;
          end else begin
            shape_base[top]  = it.base;
            shape_count[top] = it.count;
            shape_x[top]     = it.x;
            shape_y[top]     = it.y;
            exp.status       = STATUS_OK;
            exp.slot         = top[SLOT_W-1:0];
            top              = top + 1;
            placed           = placed + 1;
          end
        end
        OP_WRITE: begin
          points[it.waddr]    = it.wdata;
          point_set[it.waddr] = 1'b1;
          writes              = writes + 1;
        end
        default: begin
          top    = 0;
          clears = clears + 1;
        end
      endcase
      pending.push_back(exp);
    endfunction

    function void check_result(beam_result_t got);
      beam_result_t exp;
      if (pending.size() == 0) begin
        failures = failures + 1;
        if (failures <= 10)
          $display("mismatch %0d: unexpected result valid=%0d cursor=%h status=%0d slot=%0d",
                   failures, got.valid, got.cursor, got.status, got.slot);
        return;
      end
      exp = pending.pop_front();
      if (got.valid !== exp.valid || got.cursor !== exp.cursor ||
          got.status !== exp.status || got.slot !== exp.slot) begin
        failures = failures + 1;
        if (failures <= 10) begin
          $display("mismatch %0d: expected valid=%0d cursor=%h status=%0d slot=%0d",
                   failures, exp.valid, exp.cursor, exp.status, exp.slot);
          $display("  got valid=%0d cursor=%h status=%0d slot=%0d",
                   got.valid, got.cursor, got.status, got.slot);
        end
      end
    endfunction
  endclass

  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic                start         = 1'b0;
  logic [1:0]          mode          = MODE_TICK;
  logic [PAW-1:0]      point_base    = '0;
  logic [COUNT_W-1:0]  point_count   = '0;
  logic [OFS_W-1:0]    x_offset      = '0;
  logic [OFS_W-1:0]    y_offset      = '0;
  logic [PAW-1:0]      point_address = '0;
  logic [WORD_W-1:0]   point_value   = '0;
  logic                busy;
  logic                done;
  logic                cursor_valid;
  logic [WORD_W-1:0]   cursor;
  logic [1:0]          status;
  logic [SLOT_W-1:0]   slot;

  beam_scoreboard sb;
  int             last_base = 0;

  vector_display_list_scanner #(
    .LIST_DEPTH (LIST_N),
    .POINT_DEPTH(POINT_N)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .point_base   (point_base),
    .point_count  (point_count),
    .x_offset     (x_offset),
    .y_offset     (y_offset),
    .point_address(point_address),
    .point_value  (point_value),
    .done         (done),
    .cursor_valid (cursor_valid),
    .cursor       (cursor),
    .status       (status),
    .slot         (slot)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    if (!rst && done) sb.check_result({cursor_valid, cursor, status, slot});
  end

  function automatic list_item_t random_fields();
    list_item_t it;
    it.op    = OP_TICK;
    it.base  = PAW'($urandom_range(0, POINT_N - 1));
    it.count = COUNT_W'($urandom_range(0, POINT_N));
    it.x     = OFS_W'($urandom_range(0, 255));
    it.y     = OFS_W'($urandom_range(0, 255));
    it.waddr = PAW'($urandom_range(0, POINT_N - 1));
    it.wdata = WORD_W'($urandom_range(0, 65535));
    return it;
  endfunction

  // Called right after a rising edge; returns after the taking edge and any random gap.
  task automatic drive_item(list_item_t it, bit no_gap);
    bit taken;
    int gap;
    int r;
    start         <= 1'b1;
    mode          <= it.op;
    point_base    <= it.base;
    point_count   <= it.count;
    x_offset      <= it.x;
    y_offset      <= it.y;
    point_address <= it.waddr;
    point_value   <= it.wdata;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end
    sb.note_item(it);
    r = $urandom_range(0, 99);
    if (no_gap || r < 60) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // A tick that would land on a point never written gets that point written first.
  task automatic issue(list_item_t it, bit no_gap);
    list_item_t         fill;
    int                 s;
    int                 addr;
    logic [COUNT_W-1:0] idx;
    if (it.op == OP_TICK && sb.tick_target(s, idx)) begin
      addr = sb.point_of(s, idx);
      if (!sb.point_set[addr]) begin
        fill       = random_fields();
        fill.op    = OP_WRITE;
        fill.waddr = addr[PAW-1:0];
        drive_item(fill, no_gap);
      end
    end
    drive_item(it, no_gap);
  endtask

  task automatic directed(op_t op, int base, int count, int x, int y, int waddr, int wdata);
    list_item_t it;
    it       = random_fields();
    it.op    = op;
    it.base  = PAW'(base);
    it.count = COUNT_W'(count);
    it.x     = OFS_W'(x);
    it.y     = OFS_W'(y);
    it.waddr = PAW'(waddr);
    it.wdata = WORD_W'(wdata);
    issue(it, 1'b0);
  endtask

  task automatic run_segment(int n, int w_tick, int w_push, int w_write, bit no_gap);
    list_item_t it;
    int         r;
    int         rc;
    for (int i = 0; i < n; i++) begin
      it = random_fields();
      r  = $urandom_range(0, 99);
      if (r < w_tick) begin
        it.op = OP_TICK;
      end else if (r < w_tick + w_push) begin
        it.op = OP_PUSH;
        rc    = $urandom_range(0, 99);
        if (rc < 5) it.count = '0;
        else if (rc < 75) it.count = COUNT_W'($urandom_range(1, 8));
        else if (rc < 92) it.count = COUNT_W'($urandom_range(9, 64));
        else if (rc < 97) it.count = COUNT_W'($urandom_range(65, 600));
        else it.count = COUNT_W'(POINT_N);
        rc = $urandom_range(0, 99);
        if (rc < 35) it.base = PAW'($urandom_range(POINT_N - 32, POINT_N - 1));
        else if (rc < 70) it.base = PAW'((last_base + $urandom_range(0, 15)) % POINT_N);
        last_base = it.base;
      end else if (r < w_tick + w_push + w_write) begin
        it.op = OP_WRITE;
        if ($urandom_range(0, 99) < 60)
          it.waddr = PAW'((last_base + $urandom_range(0, 15)) % POINT_N);
      end else begin
        it.op = OP_CLEAR;
      end
      issue(it, no_gap);
    end
  endtask

  initial begin
    list_item_t it;
    int         wait_cycles;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list, empty shape, wrap of base + index, cursor overflow
    directed(OP_TICK, 0, 0, 0, 0, 0, 0);
    directed(OP_PUSH, 0, 0, 0, 0, 0, 0);
    directed(OP_WRITE, 0, 0, 0, 0, POINT_N - 1, 16'hFFFF);
    directed(OP_WRITE, 0, 0, 0, 0, 0, 16'h0000);
    directed(OP_PUSH, POINT_N - 2, 3, 255, 255, 0, 0);
    repeat (4) directed(OP_TICK, 0, 0, 0, 0, 0, 0);
    directed(OP_PUSH, 0, POINT_N, 0, 0, 0, 0);
    repeat (3) directed(OP_TICK, 0, 0, 0, 0, 0, 0);
    // clear keeps the scan position, so the next ticks hit a stale descriptor
    directed(OP_CLEAR, 0, 0, 0, 0, 0, 0);
    directed(OP_TICK, 0, 0, 0, 0, 0, 0);
    directed(OP_PUSH, 100, 2, 1, 2, 0, 0);
    repeat (2) directed(OP_TICK, 0, 0, 0, 0, 0, 0);
    directed(OP_PUSH, 200, 1, 0, 0, 0, 0);
    repeat (3) directed(OP_TICK, 0, 0, 0, 0, 0, 0);
    directed(OP_WRITE, 0, 0, 0, 0, 12'hA5A, 16'h5A5A);

    run_segment(250, 40, 25, 30, 1'b0);
    run_segment(200, 70, 10, 15, 1'b1);

    // fill the list to the brim, push into a full list, then scan it
    directed(OP_CLEAR, 0, 0, 0, 0, 0, 0);
    while (sb.top < LIST_N) begin
      it       = random_fields();
      it.op    = OP_PUSH;
      it.count = COUNT_W'($urandom_range(1, 3));
      issue(it, 1'b0);
    end
    repeat (8) begin
      it    = random_fields();
      it.op = OP_PUSH;
      if ($urandom_range(0, 1) == 0) it.count = '0;
      issue(it, 1'b0);
    end
    repeat (80) begin
      it = random_fields();
      issue(it, 1'b0);
    end
    directed(OP_CLEAR, 0, 0, 0, 0, 0, 0);

    run_segment(250, 40, 25, 28, 1'b0);
    run_segment(150, 50, 20, 25, 1'b0);

    start       <= 1'b0;
    wait_cycles  = 0;
    while (sb.pending.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $display("%0d expected results never arrived", sb.pending.size());
      sb.failures = sb.failures + sb.pending.size();
    end

    $display("run covered %0d items: %0d cursors, %0d shapes placed, %0d full, %0d empty",
             sb.items, sb.cursors, sb.placed, sb.refused, sb.empties);
    $display("  plus %0d point writes and %0d list clears; %0d failures",
             sb.writes, sb.clears, sb.failures);
    if (sb.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/vdls_pkg.sv
hdl/vdls_ram.sv
hdl/vdls_front.sv
hdl/vdls_queue.sv
hdl/vdls_back.sv
hdl/vector_display_list_scanner.sv
tb/vector_display_list_scanner_tb.sv
